// ----- rtl/mwfu_pkg.sv -----
// Package for the moving window wave field update unit.
// Holds shared widths, defaults, the action codes and the tap control struct.
// No dependencies.
package mwfu_pkg;

    // defaults for the top level parameters
    localparam int GRID_SIZE_DEF    = 1024;
    localparam int SAMPLE_WIDTH_DEF = 24;

    // fixed port widths
    localparam int INDEX_W  = 10;
    localparam int IO_SMP_W = 24;
    localparam int STEP_W   = 32;

    // action codes carried by a transaction
    typedef enum logic [1:0] {
        ACT_LOAD    = 2'd0,
        ACT_ADVANCE = 2'd1,
        ACT_READ    = 2'd2
    } action_t;

    // control from the sequencer to the tap unit at the head of the ring
    typedef struct packed {
        logic shift;     // ring rotates this cycle
        logic load_hit;  // load transaction and head slice matches the index
        logic advance;   // advance transaction in progress
        logic first;     // head slice is slice 0
        logic second;    // head slice is slice 1
    } tap_ctrl_t;

endpackage

// ----- rtl/mwfu_cell.sv -----
// One cell of the field ring: current and previous sample of one slice.
// Depends on nothing but clk/rst_n; data moves to the neighbor on shift.
module mwfu_cell #(
    parameter int SW = 24
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 shift,
    input  logic signed [SW-1:0] cur_in,
    input  logic signed [SW-1:0] prev_in,
    output logic signed [SW-1:0] cur_out,
    output logic signed [SW-1:0] prev_out
);

    logic signed [SW-1:0] cur_reg;
    logic signed [SW-1:0] prev_reg;

    // grids are cleared at reset, so these storage cells reset too
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg  <= '0;
            prev_reg <= '0;
        end
        else if (shift)
        begin
            cur_reg  <= cur_in;
            prev_reg <= prev_in;
        end
    end

    assign cur_out  = cur_reg;
    assign prev_out = prev_reg;

endmodule

// ----- rtl/mwfu_tap.sv -----
// Tap unit at the head of the field ring: leapfrog update, load and read.
// Depends on mwfu_pkg (tap_ctrl_t, IO_SMP_W).
module mwfu_tap
    import mwfu_pkg::*;
#(
    parameter int SW = 24
) (
    input  logic                       clk,
    input  tap_ctrl_t                  ctrl,
    input  logic signed [SW-1:0]       cur_in,
    input  logic signed [SW-1:0]       prev_in,
    input  logic signed [IO_SMP_W-1:0] load_sample,
    output logic signed [SW-1:0]       cur_out,
    output logic signed [SW-1:0]       prev_out,
    output logic signed [IO_SMP_W-1:0] rd_sample
);

    // old values of the two slices that passed the head before this one
    logic signed [SW-1:0] d1_cur_reg;
    logic signed [SW-1:0] d1_prev_reg;
    logic signed [SW-1:0] d2_cur_reg;
    logic signed [SW-1:0] d2_prev_reg;

    logic signed [SW+1:0] sum;
    logic signed [SW-1:0] sum_sat;
    logic signed [SW-1:0] load_val;

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            d1_cur_reg  <= cur_in;
            d1_prev_reg <= prev_in;
            d2_cur_reg  <= d1_cur_reg;
            d2_prev_reg <= d1_prev_reg;
        end
    end

    // exact three-term sum, saturated once when the top three bits disagree
    assign sum = (SW+2)'(d2_cur_reg) + (SW+2)'(cur_in) - (SW+2)'(d2_prev_reg);

    always_comb
    begin
        if ((sum[SW+1] == sum[SW]) && (sum[SW] == sum[SW-1]))
            sum_sat = sum[SW-1:0];
        else if (sum[SW+1])
            sum_sat = {1'b1, {(SW-1){1'b0}}};
        else
            sum_sat = {1'b0, {(SW-1){1'b1}}};
    end

    // load value into sample width, read value into port width
    generate
        if (SW >= IO_SMP_W)
        begin : g_wide
            assign load_val = SW'(load_sample);
            if (SW == IO_SMP_W)
            begin : g_eq
                assign rd_sample = cur_in;
            end
            else
            begin : g_gt
                always_comb
                begin
                    if (cur_in[SW-1:IO_SMP_W-1] == '0 || cur_in[SW-1:IO_SMP_W-1] == '1)
                        rd_sample = cur_in[IO_SMP_W-1:0];
                    else if (cur_in[SW-1])
                        rd_sample = {1'b1, {(IO_SMP_W-1){1'b0}}};
                    else
                        rd_sample = {1'b0, {(IO_SMP_W-1){1'b1}}};
                end
            end
        end
        else
        begin : g_narrow
            assign rd_sample = IO_SMP_W'(cur_in);
            always_comb
            begin
                if (load_sample[IO_SMP_W-1:SW-1] == '0 || load_sample[IO_SMP_W-1:SW-1] == '1)
                    load_val = load_sample[SW-1:0];
                else if (load_sample[IO_SMP_W-1])
                    load_val = {1'b1, {(SW-1){1'b0}}};
                else
                    load_val = {1'b0, {(SW-1){1'b1}}};
            end
        end
    endgenerate

    // new contents for the slice leaving the head
    always_comb
    begin
        cur_out  = cur_in;
        prev_out = prev_in;
        if (ctrl.load_hit)
        begin
            cur_out  = load_val;
            prev_out = load_val;
        end
        else if (ctrl.advance)
        begin
            prev_out = cur_in;
            if (ctrl.first)
                cur_out = '0;
            else if (ctrl.second)
                cur_out = d1_cur_reg;
            else
                cur_out = sum_sat;
        end
    end

endmodule

// ----- rtl/moving_window_wave_field_update_unit.sv -----
// Moving window wave field update unit: a ring of GRID_SIZE cells rotated past one tap.
// Each accepted transaction takes one full rotation of the cell ring, for every action;
// start is taken only while not busy, so a new transaction waits for the last one to finish.
// Reset (rst_n low, asynchronous) clears both grids and the step counter at once.
// Results are shown for one cycle on done; the receiver cannot stall.
module moving_window_wave_field_update_unit
    import mwfu_pkg::*;
#(
    parameter int GRID_SIZE    = GRID_SIZE_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 action,
    input  logic [INDEX_W-1:0]         index,
    input  logic signed [IO_SMP_W-1:0] sample_in,
    output logic                       done,
    output logic signed [IO_SMP_W-1:0] sample_out,
    output logic                       index_error,
    output logic [STEP_W-1:0]          step_count
);

    localparam int PW = $clog2(GRID_SIZE);
    localparam int SW = SAMPLE_WIDTH;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t                      state_reg, state_next;
    logic [PW-1:0]               pos_reg, pos_next;
    action_t                     action_reg, action_next;
    logic [INDEX_W-1:0]          index_reg, index_next;
    logic signed [IO_SMP_W-1:0]  sample_reg, sample_next;
    logic                        err_reg, err_next;
    logic signed [IO_SMP_W-1:0]  rd_reg, rd_next;
    logic                        done_reg, done_next;
    logic signed [IO_SMP_W-1:0]  sample_out_reg, sample_out_next;
    logic                        index_error_reg, index_error_next;
    logic [STEP_W-1:0]           step_reg, step_next;

    logic                        hit;
    logic                        last;
    tap_ctrl_t                   ctrl;
    logic signed [IO_SMP_W-1:0]  rd_sample;
    logic signed [SW-1:0]        tap_cur, tap_prev;

    logic signed [SW-1:0] cur_q  [GRID_SIZE];
    logic signed [SW-1:0] prev_q [GRID_SIZE];

    assign hit  = (32'(pos_reg) == 32'(index_reg));
    assign last = (pos_reg == PW'(GRID_SIZE - 1));

    // tap control
    assign ctrl.shift    = (state_reg == ST_RUN);
    assign ctrl.load_hit = (state_reg == ST_RUN) && (action_reg == ACT_LOAD) && hit;
    assign ctrl.advance  = (state_reg == ST_RUN) && (action_reg == ACT_ADVANCE);
    assign ctrl.first    = (pos_reg == '0);
    assign ctrl.second   = (pos_reg == PW'(1));

    // ring of cells; the tail takes the updated head slice
    genvar gi;
    generate
        for (gi = 0; gi < GRID_SIZE; gi++)
        begin : g_ring
            if (gi == GRID_SIZE - 1)
            begin : g_tail
                mwfu_cell #(.SW(SW)) u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .shift    (ctrl.shift),
                    .cur_in   (tap_cur),
                    .prev_in  (tap_prev),
                    .cur_out  (cur_q[gi]),
                    .prev_out (prev_q[gi])
                );
            end
            else
            begin : g_body
                mwfu_cell #(.SW(SW)) u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .shift    (ctrl.shift),
                    .cur_in   (cur_q[gi+1]),
                    .prev_in  (prev_q[gi+1]),
                    .cur_out  (cur_q[gi]),
                    .prev_out (prev_q[gi])
                );
            end
        end
    endgenerate

    mwfu_tap #(.SW(SW)) u_tap (
        .clk         (clk),
        .ctrl        (ctrl),
        .cur_in      (cur_q[0]),
        .prev_in     (prev_q[0]),
        .load_sample (sample_reg),
        .cur_out     (tap_cur),
        .prev_out    (tap_prev),
        .rd_sample   (rd_sample)
    );

    // sequencer next state
    always_comb
    begin
        state_next       = state_reg;
        pos_next         = pos_reg;
        action_next      = action_reg;
        index_next       = index_reg;
        sample_next      = sample_reg;
        err_next         = err_reg;
        rd_next          = rd_reg;
        done_next        = 1'b0;
        sample_out_next  = sample_out_reg;
        index_error_next = index_error_reg;
        step_next        = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next  = ST_RUN;
                    pos_next    = '0;
                    action_next = action_t'(action);
                    index_next  = index;
                    sample_next = sample_in;
                    err_next    = ((action_t'(action) == ACT_LOAD) ||
                                   (action_t'(action) == ACT_READ)) &&
                                  !(32'(index) < 32'(GRID_SIZE));
                end
            end
            ST_RUN:
            begin
                pos_next = pos_reg + 1'b1;
                if (hit && (action_reg == ACT_READ))
                    rd_next = rd_sample;
                if (last)
                begin
                    state_next       = ST_IDLE;
                    pos_next         = '0;
                    done_next        = 1'b1;
                    index_error_next = err_reg;
                    if ((action_reg == ACT_READ) && !err_reg)
                        sample_out_next = hit ? rd_sample : rd_reg;
                    else
                        sample_out_next = '0;
                    if (action_reg == ACT_ADVANCE)
                        step_next = step_reg + 32'd1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            pos_reg         <= '0;
            done_reg        <= 1'b0;
            step_reg        <= '0;
            sample_out_reg  <= '0;
            index_error_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            pos_reg         <= pos_next;
            done_reg        <= done_next;
            step_reg        <= step_next;
            sample_out_reg  <= sample_out_next;
            index_error_reg <= index_error_next;
        end
    end

    // transaction payload, no reset needed
    always_ff @(posedge clk)
    begin
        action_reg <= action_next;
        index_reg  <= index_next;
        sample_reg <= sample_next;
        err_reg    <= err_next;
        rd_reg     <= rd_next;
    end

    assign busy        = (state_reg == ST_RUN);
    assign done        = done_reg;
    assign sample_out  = sample_out_reg;
    assign index_error = index_error_reg;
    assign step_count  = step_reg;

endmodule

// ----- rtl/mwfu_checker.sv -----
// Port-level checks for the moving window wave field update unit, bound to the top level.
// Depends on mwfu_pkg for port widths.
module mwfu_checker
    import mwfu_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       done,
    input logic signed [IO_SMP_W-1:0] sample_out,
    input logic                       index_error,
    input logic [STEP_W-1:0]          step_count
);

    // an accepted transaction makes the unit busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted start");

    // a result is shown only right after the unit stops being busy
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!busy && $past(busy)))
        else $error("done without a finished transaction");

    // an index error carries a zero sample
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && index_error) |-> (sample_out == '0))
        else $error("nonzero sample with index error");

    // the step count moves only with a result, and by one
    a_step_moves: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(step_count) |-> (done && (step_count == $past(step_count) + 32'd1)))
        else $error("step count changed outside a result");

    // the unit stays idle without a start
    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy && !start) |=> !busy)
        else $error("busy raised without start");

endmodule

bind moving_window_wave_field_update_unit mwfu_checker u_mwfu_checker (.*);

// ----- test/tb.sv -----
// Testbench for the moving window wave field update unit.
// Drives load, advance, read and unused-code transactions and checks every result
// against a local leapfrog predictor. Depends on rtl/mwfu_pkg.sv and the top level.
`timescale 1ns / 1ps

module tb;
    import mwfu_pkg::*;

    localparam int GRID          = GRID_SIZE_DEF;
    localparam int CYCLE_LIMIT   = 3_000_000;
    localparam int DRAIN_CYCLES  = GRID + 16;
    localparam int RANDOM_PER_PHASE = 135;

    // action code the block leaves unused
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam logic signed [IO_SMP_W-1:0] SMP_MAX = 24'sh7FFFFF;
    localparam logic signed [IO_SMP_W-1:0] SMP_MIN = 24'sh800000;
    localparam logic signed [IO_SMP_W+1:0] SUM_MAX = 26'sd8388607;
    localparam logic signed [IO_SMP_W+1:0] SUM_MIN = -26'sd8388608;

    typedef struct {
        logic [1:0]                 action;
        logic [INDEX_W-1:0]         index;
        logic signed [IO_SMP_W-1:0] sample;
    } cmd_t;

    typedef struct {
        logic signed [IO_SMP_W-1:0] sample;
        logic                       err;
        logic [STEP_W-1:0]          steps;
    } result_t;

    logic                       clk;
    logic                       rst_n;
    logic                       start;
    logic                       busy;
    logic [1:0]                 action;
    logic [INDEX_W-1:0]         index;
    logic signed [IO_SMP_W-1:0] sample_in;
    logic                       done;
    logic signed [IO_SMP_W-1:0] sample_out;
    logic                       index_error;
    logic [STEP_W-1:0]          step_count;

    cmd_t    pending_cmds[$];
    result_t expected_results[$];

    // predictor state
    logic signed [IO_SMP_W-1:0] cur_field[GRID];
    logic signed [IO_SMP_W-1:0] prev_field[GRID];
    logic [STEP_W-1:0]          advance_count;

    int  errors;
    int  cycles;
    int  idle_pct;
    logic took_item;

    moving_window_wave_field_update_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .action      (action),
        .index       (index),
        .sample_in   (sample_in),
        .done        (done),
        .sample_out  (sample_out),
        .index_error (index_error),
        .step_count  (step_count)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // saturate an exact three-term sum to the sample range
    function automatic logic signed [IO_SMP_W-1:0] clamp_sample(logic signed [IO_SMP_W+1:0] v);
        if (v > SUM_MAX)
            return SMP_MAX;
        if (v < SUM_MIN)
            return SMP_MIN;
        return v[IO_SMP_W-1:0];
    endfunction

    // apply one transaction to the predicted grids and return the expected result
    function automatic result_t field_step(cmd_t c);
        result_t r;
        logic signed [IO_SMP_W+1:0] sum;
        r.sample = '0;
        r.err    = 1'b0;
        if (c.action == ACT_LOAD) begin
            if (c.index < GRID) begin
                cur_field[c.index]  = c.sample;
                prev_field[c.index] = c.sample;
            end
            else
                r.err = 1'b1;
        end
        else if (c.action == ACT_ADVANCE) begin
            // top down so cur[j-2] is still the old value
            for (int j = GRID - 1; j >= 2; j--) begin
                sum = cur_field[j-2] + cur_field[j] - prev_field[j-2];
                prev_field[j] = cur_field[j];
                cur_field[j]  = clamp_sample(sum);
            end
            prev_field[1] = cur_field[1];
            cur_field[1]  = cur_field[0];
            prev_field[0] = cur_field[0];
            cur_field[0]  = '0;
            advance_count = advance_count + 1;
        end
        else if (c.action == ACT_READ) begin
            if (c.index < GRID)
                r.sample = cur_field[c.index];
            else
                r.err = 1'b1;
        end
        r.steps = advance_count;
        return r;
    endfunction

    // driver: present the next pending command on the falling edge
    always @(negedge clk)
    begin
        cmd_t c;
        logic holding;
        if (rst_n) begin
            holding = start && !took_item;
            if (!holding) begin
                if (pending_cmds.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    c = pending_cmds.pop_front();
                    action    <= c.action;
                    index     <= c.index;
                    sample_in <= c.sample;
                    start     <= 1'b1;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // monitor: check results and record accepted transactions on the rising edge
    always @(posedge clk)
    begin
        result_t want;
        cmd_t c;
        if (rst_n) begin
            if (done) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result: sample_out=%0d index_error=%0b",
                             $time, sample_out, index_error);
                    $display("%0t: unexpected result: step_count=%0d", $time, step_count);
                    errors++;
                end
                else begin
                    want = expected_results.pop_front();
                    if (sample_out !== want.sample) begin
                        $display("%0t: sample_out mismatch: expected %0d, actual %0d",
                                 $time, want.sample, sample_out);
                        errors++;
                    end
                    if (index_error !== want.err) begin
                        $display("%0t: index_error mismatch: expected %0b, actual %0b",
                                 $time, want.err, index_error);
                        errors++;
                    end
                    if (step_count !== want.steps) begin
                        $display("%0t: step_count mismatch: expected %0d, actual %0d",
                                 $time, want.steps, step_count);
                        errors++;
                    end
                end
            end
            if (start && !busy) begin
                c.action = action;
                c.index  = index;
                c.sample = sample_in;
                expected_results.insert(expected_results.size(), field_step(c));
                took_item <= 1'b1;
            end
            else
                took_item <= 1'b0;
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic queue_cmd(logic [1:0] act, int idx, logic signed [IO_SMP_W-1:0] smp);
        cmd_t c;
        c.action = act;
        c.index  = idx[INDEX_W-1:0];
        c.sample = smp;
        pending_cmds.insert(pending_cmds.size(), c);
    endtask

    // extremes often, small values sometimes, full range otherwise
    function automatic logic signed [IO_SMP_W-1:0] rand_sample();
        case ($urandom_range(9))
            0: return SMP_MAX;
            1: return SMP_MIN;
            2: return IO_SMP_W'(int'($urandom_range(255)) - 128);
            default: return IO_SMP_W'($urandom);
        endcase
    endfunction

    // mostly near the low end where the dynamics live, sometimes anywhere or at the top index
    function automatic int rand_index(int lo_span);
        case ($urandom_range(9))
            0: return GRID - 1;
            1, 2, 3: return $urandom_range(GRID - 1);
            default: return $urandom_range(lo_span);
        endcase
    endfunction

    // load a few seeds, step a few times, then read around the active region
    task automatic queue_burst(ref int budget);
        int n_load;
        int n_adv;
        int n_read;
        n_load = $urandom_range(4, 1);
        n_adv  = $urandom_range(5, 1);
        n_read = $urandom_range(4, 2);
        for (int i = 0; i < n_load; i++)
            queue_cmd(ACT_LOAD, rand_index(15), rand_sample());
        for (int i = 0; i < n_adv; i++)
            queue_cmd(ACT_ADVANCE, $urandom_range(GRID - 1), IO_SMP_W'($urandom));
        for (int i = 0; i < n_read; i++)
            queue_cmd(ACT_READ, rand_index(15 + 2 * n_adv), IO_SMP_W'($urandom));
        budget -= n_load + n_adv + n_read;
    endtask

    // noise: any action, any field values
    task automatic queue_noise();
        logic [1:0] act;
        act = 2'($urandom_range(3));
        if (act == ACT_UNUSED && $urandom_range(1))
            act = ACT_READ;
        queue_cmd(act, $urandom_range(GRID - 1), IO_SMP_W'($urandom));
    endtask

    task automatic wait_drained();
        while (pending_cmds.size() > 0 || start || expected_results.size() > 0)
            @(posedge clk);
    endtask

    // stimulus
    initial
    begin
        int budget;
        int phase_idle[4];
        phase_idle = '{0, 71, 24, 0};
        rst_n     = 1'b0;
        start     = 1'b0;
        action    = ACT_LOAD;
        index     = '0;
        sample_in = '0;
        took_item = 1'b0;
        errors    = 0;
        cycles    = 0;
        idle_pct  = 0;
        advance_count = '0;
        for (int i = 0; i < GRID; i++) begin
            cur_field[i]  = '0;
            prev_field[i] = '0;
        end
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, each action, unused code, positive and negative overflow
        queue_cmd(ACT_READ, 0, '0);
        queue_cmd(ACT_LOAD, GRID - 1, SMP_MIN);
        queue_cmd(ACT_LOAD, 5, SMP_MAX);
        queue_cmd(ACT_READ, GRID - 1, SMP_MAX);
        queue_cmd(ACT_READ, 5, '0);
        queue_cmd(ACT_UNUSED, GRID - 1, SMP_MIN);
        queue_cmd(ACT_LOAD, 0, SMP_MIN);
        queue_cmd(ACT_LOAD, 2, SMP_MAX);
        queue_cmd(ACT_ADVANCE, GRID - 1, SMP_MAX);
        queue_cmd(ACT_READ, 1, '0);
        queue_cmd(ACT_ADVANCE, 0, '0);
        queue_cmd(ACT_READ, 2, '0);
        queue_cmd(ACT_READ, 4, '0);
        queue_cmd(ACT_LOAD, 0, SMP_MAX);
        queue_cmd(ACT_LOAD, 2, SMP_MIN);
        queue_cmd(ACT_ADVANCE, 0, '0);
        queue_cmd(ACT_ADVANCE, 0, '0);
        queue_cmd(ACT_READ, 2, '0);
        queue_cmd(ACT_READ, 3, '0);
        queue_cmd(ACT_READ, 6, '0);
        queue_cmd(ACT_UNUSED, 0, '0);
        queue_cmd(ACT_READ, GRID - 1, '0);
        wait_drained();

        // random phases, with sender idling set per phase
        foreach (phase_idle[p]) begin
            idle_pct = phase_idle[p];
            budget = RANDOM_PER_PHASE;
            while (budget > 0) begin
                if ($urandom_range(4) == 0) begin
                    queue_noise();
                    budget--;
                end
                else
                    queue_burst(budget);
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/mwfu_pkg.sv
rtl/mwfu_cell.sv
rtl/mwfu_tap.sv
rtl/moving_window_wave_field_update_unit.sv
rtl/mwfu_checker.sv
test/tb.sv
